[rtl/rau_pkg.sv]
// Package for the rational arithmetic unit: widths, command and status codes,
// sequencer and divider state types. No dependencies.
`default_nettype none
package rau_pkg;
   localparam int VALUE_WIDTH = 32;
   localparam int WIDE_WIDTH  = 2 * VALUE_WIDTH + 1;   // magnitude of 64-bit intermediates
   localparam int CNT_WIDTH   = $clog2(WIDE_WIDTH + 1);

   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_SUB    = 3'd1;
   localparam logic [2:0] CMD_MUL    = 3'd2;
   localparam logic [2:0] CMD_DIV    = 3'd3;
   localparam logic [2:0] CMD_LT     = 3'd4;
   localparam logic [2:0] CMD_GT     = 3'd5;
   localparam logic [2:0] CMD_SPARE0 = 3'd6;   // no operation, result 0/1
   localparam logic [2:0] CMD_SPARE1 = 3'd7;   // no operation, result 0/1

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RED_START,   // start a reduction: setup Euclid operands
      S_EUC_WAIT,    // a mod b in divider
      S_EUC_NEXT,
      S_QN_WAIT,     // num / g
      S_QD_WAIT,     // den / g
      S_RED_END,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_COMBINE,
      S_OUT
   } seq_state_type;
endpackage
`default_nettype wire

[rtl/rau_divider.sv]
// Shared restoring divider for the rational arithmetic unit, one quotient bit
// per cycle on unsigned wide magnitudes. Depends on rau_pkg.
`default_nettype none
module rau_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rau_pkg::WIDE_WIDTH-1:0] dividend,
   input  wire logic [rau_pkg::WIDE_WIDTH-1:0] divisor,
   output logic                               done,
   output logic [rau_pkg::WIDE_WIDTH-1:0]     quotient,
   output logic [rau_pkg::WIDE_WIDTH-1:0]     remainder
);
   import rau_pkg::*;

   div_state_type             state_ff, state_in;
   logic [WIDE_WIDTH-1:0]     quo_ff, quo_in;
   logic [WIDE_WIDTH-1:0]     rem_ff, rem_in;
   logic [WIDE_WIDTH-1:0]     dvs_ff, dvs_in;
   logic [CNT_WIDTH-1:0]      cnt_ff, cnt_in;
   logic [WIDE_WIDTH:0]       trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      trial    = {rem_ff, quo_ff[WIDE_WIDTH-1]} - {1'b0, dvs_ff};
      done     = 1'b0;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               quo_in   = dividend;
               rem_in   = '0;
               dvs_in   = divisor;
               cnt_in   = CNT_WIDTH'(WIDE_WIDTH);
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            // shift one dividend bit in; keep the difference when it does not go negative
            if (!trial[WIDE_WIDTH]) begin
               rem_in = trial[WIDE_WIDTH-1:0];
               quo_in = {quo_ff[WIDE_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[WIDE_WIDTH-2:0], quo_ff[WIDE_WIDTH-1]};
               quo_in = {quo_ff[WIDE_WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_WIDTH'(1)) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            // a new start is accepted in the same cycle as done
            done     = 1'b1;
            state_in = DIV_IDLE;
            if (start) begin
               quo_in   = dividend;
               rem_in   = '0;
               dvs_in   = divisor;
               cnt_in   = CNT_WIDTH'(WIDE_WIDTH);
               state_in = DIV_RUN;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

[rtl/rational_arithmetic_unit.sv]
// Top level of the rational arithmetic unit: handshake, sequencer, shared
// multiplier and the rau_divider instance. Depends on rau_pkg and rau_divider.
`default_nettype none
// One transfer on req_ carries a command and two signed fractions; one
// transfer on rsp_ returns the reduced result, the compare outcome and a
// status code. The block works on one item at a time and holds req_stall high
// from acceptance until the result is loaded into the output register; a
// result waiting there does not block the next item, but that item is held
// at its end until the waiting result is taken. Each reduction (two operands,
// then the result for add, subtract, multiply and divide) runs Euclid's
// algorithm on a shared bit-serial divider, one divide per a mod b step,
// followed by two more divides for the quotients. The worst case is set by
// the number of Euclid steps (about 1.44 log2 of the operands, up to ~93
// steps for 64-bit intermediates). The cross products use one 32x32
// multiplier, one product per cycle.
module rational_arithmetic_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [2:0]                    req_command,
   input  wire logic signed [rau_pkg::VALUE_WIDTH-1:0] req_left_numerator,
   input  wire logic signed [rau_pkg::VALUE_WIDTH-1:0] req_left_denominator,
   input  wire logic signed [rau_pkg::VALUE_WIDTH-1:0] req_right_numerator,
   input  wire logic signed [rau_pkg::VALUE_WIDTH-1:0] req_right_denominator,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [rau_pkg::VALUE_WIDTH-1:0] rsp_result_numerator,
   output logic [rau_pkg::VALUE_WIDTH-2:0]    rsp_result_denominator,
   output logic                               rsp_compare_true,
   output logic [1:0]                         rsp_status
);
   import rau_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int WW = WIDE_WIDTH;
   localparam logic [WW-1:0] LIM = WW'(1) << (VW - 1);

   seq_state_type state_ff, state_in;

   // captured item
   logic [2:0]          cmd_ff, cmd_in;
   logic signed [VW-1:0] ln_ff, ld_ff, rn_ff, rd_ff;
   logic signed [VW-1:0] ln_in, ld_in, rn_in, rd_in;

   // reduction phase: 0 left operand, 1 right operand, 2 result
   logic [1:0]          phase_ff, phase_in;
   logic [WW-1:0]       ea_ff, ea_in, eb_ff, eb_in;        // Euclid pair
   logic [WW-1:0]       un_ff, un_in, ud_ff, ud_in;        // magnitudes being reduced
   logic                rneg_ff, rneg_in;                  // sign of n/d
   logic [WW-1:0]       qn_ff, qn_in;

   // reduced operands, sign and magnitude
   logic                an_neg_ff, an_neg_in, bn_neg_ff, bn_neg_in;
   logic [VW-1:0]       an_ff, an_in, bn_ff, bn_in;        // magnitude up to 2^(VW-1)
   logic [VW-1:0]       ad_ff, ad_in, bd_ff, bd_in;

   // products and combined result
   logic [2*VW-1:0]     p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic                p0_neg_ff, p0_neg_in, p1_neg_ff, p1_neg_in;

   // working result of the item in progress
   logic signed [VW-1:0] onum_ff, onum_in;
   logic [VW-2:0]       oden_ff, oden_in;
   logic                ocmp_ff, ocmp_in;
   logic [1:0]          ost_ff, ost_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0] rnum_ff, rnum_in;
   logic [VW-2:0]       rden_ff, rden_in;
   logic                rcmp_ff, rcmp_in;
   logic [1:0]          rstat_ff, rstat_in;

   // shared multiplier
   logic [VW-1:0]       mul_a, mul_b;
   logic [2*VW-1:0]     mul_p;

   // divider
   logic                div_start, div_done;
   logic [WW-1:0]       div_dividend, div_divisor, div_quo, div_rem;

   // helpers
   logic [WW-1:0]       sum_pos, sum_neg_mag, sum_mag;
   logic                sum_neg;
   logic signed [WW:0]  sa, sb, sdiff;
   logic                fit_ok;
   logic [WW-1:0]       qd;

   assign mul_p = mul_a * mul_b;

   rau_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in; ln_ff <= ln_in; ld_ff <= ld_in; rn_ff <= rn_in; rd_ff <= rd_in;
      phase_ff <= phase_in; ea_ff <= ea_in; eb_ff <= eb_in;
      un_ff <= un_in; ud_ff <= ud_in; rneg_ff <= rneg_in; qn_ff <= qn_in;
      an_neg_ff <= an_neg_in; bn_neg_ff <= bn_neg_in;
      an_ff <= an_in; bn_ff <= bn_in; ad_ff <= ad_in; bd_ff <= bd_in;
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in;
      p0_neg_ff <= p0_neg_in; p1_neg_ff <= p1_neg_in;
      onum_ff <= onum_in; oden_ff <= oden_in; ocmp_ff <= ocmp_in; ost_ff <= ost_in;
      rnum_ff <= rnum_in; rden_ff <= rden_in; rcmp_ff <= rcmp_in; rstat_ff <= rstat_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; ln_in = ln_ff; ld_in = ld_ff; rn_in = rn_ff; rd_in = rd_ff;
      phase_in = phase_ff; ea_in = ea_ff; eb_in = eb_ff;
      un_in = un_ff; ud_in = ud_ff; rneg_in = rneg_ff; qn_in = qn_ff;
      an_neg_in = an_neg_ff; bn_neg_in = bn_neg_ff;
      an_in = an_ff; bn_in = bn_ff; ad_in = ad_ff; bd_in = bd_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff;
      p0_neg_in = p0_neg_ff; p1_neg_in = p1_neg_ff;
      rsp_valid_in = rsp_valid_ff;
      onum_in = onum_ff; oden_in = oden_ff; ocmp_in = ocmp_ff; ost_in = ost_ff;
      rnum_in = rnum_ff; rden_in = rden_ff; rcmp_in = rcmp_ff; rstat_in = rstat_ff;
      mul_a = an_ff; mul_b = bd_ff;
      div_start = 1'b0;
      div_dividend = ea_ff;
      div_divisor = eb_ff;
      qd = div_quo;

      // result fit check on the just-finished quotient pair (qn_ff, div_quo)
      fit_ok = (qd != '0) && (qd <= LIM - 1'b1) &&
               (rneg_ff ? (qn_ff <= LIM) : (qn_ff <= LIM - 1'b1));

      // signed sum, or difference for subtract, of the two cross products
      sa = p0_neg_ff ? -$signed({1'b0, WW'(p0_ff)}) : $signed({1'b0, WW'(p0_ff)});
      sb = p1_neg_ff ? -$signed({1'b0, WW'(p1_ff)}) : $signed({1'b0, WW'(p1_ff)});
      sdiff = (cmd_ff == CMD_SUB) ? (sa - sb) : (sa + sb);
      sum_neg = sdiff[WW];
      sum_neg_mag = WW'(-sdiff);
      sum_pos = WW'(sdiff);
      sum_mag = sum_neg ? sum_neg_mag : sum_pos;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command;
               ln_in = req_left_numerator; ld_in = req_left_denominator;
               rn_in = req_right_numerator; rd_in = req_right_denominator;
               onum_in = '0; oden_in = (VW-1)'(1); ocmp_in = 1'b0; ost_in = ST_OK;
               phase_in = 2'd0;
               if (req_left_denominator == '0 || req_right_denominator == '0) begin
                  ost_in = ST_ZERO_DEN;
                  state_in = S_OUT;
               end else begin
                  state_in = S_RED_START;
               end
            end
         end
         S_RED_START: begin
            // drop sign, remember whether n/d is negative
            if (phase_ff == 2'd0) begin
               un_in = ln_ff[VW-1] ? WW'(-{{(WW-VW){ln_ff[VW-1]}}, ln_ff})
                                   : WW'($unsigned(ln_ff));
               ud_in = ld_ff[VW-1] ? WW'(-{{(WW-VW){ld_ff[VW-1]}}, ld_ff})
                                   : WW'($unsigned(ld_ff));
               rneg_in = ln_ff[VW-1] ^ ld_ff[VW-1];
            end else begin
               un_in = rn_ff[VW-1] ? WW'(-{{(WW-VW){rn_ff[VW-1]}}, rn_ff})
                                   : WW'($unsigned(rn_ff));
               ud_in = rd_ff[VW-1] ? WW'(-{{(WW-VW){rd_ff[VW-1]}}, rd_ff})
                                   : WW'($unsigned(rd_ff));
               rneg_in = rn_ff[VW-1] ^ rd_ff[VW-1];
            end
            ea_in = un_in;
            eb_in = ud_in;
            state_in = S_EUC_NEXT;
         end
         S_EUC_NEXT: begin
            // advance Euclid: stop when b is zero, a holds the gcd
            if (eb_ff == '0) begin
               div_start = 1'b1;
               div_dividend = un_ff;
               div_divisor = ea_ff;
               state_in = S_QN_WAIT;
            end else begin
               div_start = 1'b1;
               state_in = S_EUC_WAIT;
            end
         end
         S_EUC_WAIT: begin
            if (div_done) begin
               ea_in = eb_ff;
               eb_in = div_rem;
               state_in = S_EUC_NEXT;
            end
         end
         S_QN_WAIT: begin
            if (div_done) begin
               qn_in = div_quo;
               div_start = 1'b1;
               div_dividend = ud_ff;
               div_divisor = ea_ff;
               state_in = S_QD_WAIT;
            end
         end
         S_QD_WAIT: begin
            if (div_done) begin
               state_in = S_RED_END;
               if (!fit_ok) begin
                  ost_in = ST_OVERFLOW;
                  state_in = S_OUT;
               end else if (phase_ff == 2'd0) begin
                  an_neg_in = rneg_ff && (qn_ff != '0);
                  an_in = VW'(qn_ff);
                  ad_in = VW'(qd);
               end else if (phase_ff == 2'd1) begin
                  bn_neg_in = rneg_ff && (qn_ff != '0);
                  bn_in = VW'(qn_ff);
                  bd_in = VW'(qd);
               end else begin
                  if (qn_ff != '0) begin
                     onum_in = (rneg_ff ? -VW'(qn_ff) : VW'(qn_ff));
                     oden_in = (VW-1)'(qd);
                  end
                  state_in = S_OUT;
               end
            end
         end
         S_RED_END: begin
            if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
               state_in = S_RED_START;
            end else begin
               phase_in = 2'd2;
               state_in = S_MUL0;
               if (cmd_ff == CMD_DIV && bn_ff == '0) begin
                  ost_in = ST_DIV_ZERO;
                  state_in = S_OUT;
               end else if (cmd_ff != CMD_ADD && cmd_ff != CMD_SUB && cmd_ff != CMD_MUL &&
                            cmd_ff != CMD_DIV && cmd_ff != CMD_LT && cmd_ff != CMD_GT) begin
                  state_in = S_OUT;
               end
            end
         end
         S_MUL0: begin
            // p0 = an*bd (or an*bn for multiply)
            mul_a = an_ff;
            mul_b = (cmd_ff == CMD_MUL) ? bn_ff : bd_ff;
            p0_in = mul_p;
            p0_neg_in = an_neg_ff ^ ((cmd_ff == CMD_MUL) ? bn_neg_ff : 1'b0);
            state_in = S_MUL1;
         end
         S_MUL1: begin
            // p1 = bn*ad
            mul_a = bn_ff;
            mul_b = ad_ff;
            p1_in = mul_p;
            p1_neg_in = bn_neg_ff;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            // p2 = denominator: ad*bd, or ad*|bn| for divide
            mul_a = ad_ff;
            mul_b = (cmd_ff == CMD_DIV) ? bn_ff : bd_ff;
            p2_in = mul_p;
            state_in = S_COMBINE;
         end
         S_COMBINE: begin
            state_in = S_RED_START;
            case (cmd_ff)
               CMD_ADD, CMD_SUB: begin
                  un_in = sum_mag;
                  rneg_in = sum_neg;
               end
               CMD_MUL: begin
                  un_in = WW'(p0_ff);
                  rneg_in = p0_neg_ff;
               end
               CMD_DIV: begin
                  un_in = WW'(p0_ff);
                  rneg_in = an_neg_ff ^ bn_neg_ff;
               end
               CMD_LT: begin
                  ocmp_in = sdiff[WW] && (sdiff != '0);
                  state_in = S_OUT;
               end
               CMD_GT: begin
                  ocmp_in = !sdiff[WW] && (sdiff != '0);
                  state_in = S_OUT;
               end
               default: state_in = S_OUT;
            endcase
            ud_in = WW'(p2_ff);
            ea_in = un_in;
            eb_in = ud_in;
            if (state_in == S_RED_START) begin
               state_in = S_EUC_NEXT;
            end
         end
         S_OUT: begin
            // hold until the output register is free, then move the result there
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rnum_in = onum_ff;
               rden_in = oden_ff;
               rcmp_in = ocmp_ff;
               rstat_in = ost_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // compare uses an*bd - bn*ad: reuse the subtract path
      if (state_ff == S_COMBINE && (cmd_ff == CMD_LT || cmd_ff == CMD_GT)) begin
         sdiff = sa - sb;
         ocmp_in = (cmd_ff == CMD_LT) ? (sdiff[WW] == 1'b1)
                                      : (!sdiff[WW] && (sdiff != '0));
      end
   end

   assign req_stall              = (state_ff != S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_numerator   = rnum_ff;
   assign rsp_result_denominator = rden_ff;
   assign rsp_compare_true       = rcmp_ff;
   assign rsp_status             = rstat_ff;
endmodule
`default_nettype wire
